[sv/sprb_pkg.sv]
// ----------------------------------------------------------------------------
// sprb_pkg
// Shared types, register map constants and decode helpers for the S/PDIF
// transceiver register block.
// ----------------------------------------------------------------------------
package sprb_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_t;

  // Register write flavors selected by the alias sub-offset
  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_SET   = 2'd1,
    OP_CLR   = 2'd2,
    OP_TOG   = 2'd3
  } reg_op_t;

  // Address map
  localparam int          REG_BASE     = 2048;
  localparam logic [11:0] OFF_RX_PORT  = 12'hc00;
  localparam logic [11:0] OFF_TX_PORT  = 12'he00;
  localparam logic [10:0] REL_AI_WDATA = 11'h0a0;
  localparam logic [10:0] REL_AI_RDATA = 11'h0a4;

  // Word indexes of the registers that the datapath itself uses
  localparam logic [8:0] IDX_EXT_CTRL = 9'd4;
  localparam logic [8:0] IDX_AI_CTRL  = 9'd36;
  localparam logic [8:0] IDX_AI_WDATA = 9'd40;
  localparam logic [8:0] IDX_AI_RDATA = 9'd41;

  localparam logic [31:0] VERSION_WORD = 32'h0001_0000;

  // Indirect control bits
  localparam int AI_READ_BIT     = 31;
  localparam int AI_TOG_PLL_BIT  = 24;
  localparam int AI_DONE_PLL_BIT = 25;
  localparam int AI_TOG_PHY_BIT  = 26;
  localparam int AI_DONE_PHY_BIT = 27;

  // EXT_CTRL bits
  localparam int EC_SPDIF_BIT      = 23;
  localparam int EC_DMA_WR_DIS_BIT = 24;
  localparam int EC_TX_RESET_BIT   = 27;
  localparam int WM_W              = 7;

  // Indirect store geometry
  localparam int IND_DEPTH = 256;
  localparam int IND_AW    = 8;

  // Byte lanes of the window RAM
  localparam int LANES = 4;

  // Clearing pass row counter (covers the largest memory row count)
  localparam int CLR_ROW_W = 9;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic [2:0]  access_bytes;
  } item_t;

  typedef struct packed {
    logic                 active;
    logic [CLR_ROW_W-1:0] row;
  } clr_t;

  typedef struct packed {
    logic [31:0] word;
    logic        valid;
    logic        dreq;
    logic [5:0]  level;
  } tx_res_t;

  typedef struct packed {
    logic [8:0] idx;
    reg_op_t    op;
  } reg_sel_t;

  // Resolve the target word and write flavor of a register offset
  function automatic reg_sel_t reg_select(input logic [11:0] offset);
    reg_sel_t    sel;
    logic [10:0] rel;
    rel     = 11'(offset - 12'(REG_BASE));
    sel.idx = rel[10:2];
    sel.op  = OP_PLAIN;
    if (rel != REL_AI_WDATA && rel != REL_AI_RDATA) begin
      case (rel[3:0])
        4'h4: begin
          sel.idx = {rel[10:4], 2'b00};
          sel.op  = OP_SET;
        end
        4'h8: begin
          sel.idx = {rel[10:4], 2'b00};
          sel.op  = OP_CLR;
        end
        4'hc: begin
          sel.idx = {rel[10:4], 2'b00};
          sel.op  = OP_TOG;
        end
        default: ;
      endcase
    end
    return sel;
  endfunction

  // Apply a write flavor to the current register value
  function automatic logic [31:0] reg_apply(input reg_op_t op, input logic [31:0] cur,
                                            input logic [31:0] val);
    logic [31:0] res;
    case (op)
      OP_SET:  res = cur | val;
      OP_CLR:  res = cur & ~val;
      OP_TOG:  res = cur ^ val;
      default: res = val;
    endcase
    return res;
  endfunction

endpackage

[sv/sprb_ram.sv]
// ----------------------------------------------------------------------------
// sprb_ram
// Generic single write port, single read port RAM with registered read.
// A read that meets a write to the same address returns the new data.
// ----------------------------------------------------------------------------
module sprb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, then read with write-first forwarding
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= (we && waddr == raddr) ? wdata : mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

[sv/sprb_win.sv]
// ----------------------------------------------------------------------------
// sprb_win
// Little-endian byte window RAM built from four byte-lane memories, with
// unaligned accesses of one to four bytes.
// ----------------------------------------------------------------------------
module sprb_win #(
  parameter int RAM_BYTES = 2048
) (
  input  logic                 clk,
  input  sprb_pkg::clr_t       clr,
  input  logic                 rd_en,
  input  logic [11:0]          rd_offset,
  input  sprb_pkg::item_t      s1_item,
  input  logic                 wr_en,
  output logic [31:0]          rdata
);
  import sprb_pkg::*;

  localparam int ROWS = (RAM_BYTES + 3) / 4;
  localparam int AW   = ROWS > 1 ? $clog2(ROWS) : 1;

  logic [2:0]             nbytes;
  logic [LANES-1:0][7:0]  lane_q;
  logic [LANES-1:0][31:0] lane_part;

  // Clamp the access size to one word
  assign nbytes = (s1_item.access_bytes > 3'd4) ? 3'd4 : s1_item.access_bytes;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [1:0]    rd_pos;
    logic [12:0]   rd_byte;
    logic [1:0]    s1_pos;
    logic [12:0]   s1_byte;
    logic          hit;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    // Map this lane to a byte position of the access and a byte address
    always_comb begin
      rd_pos  = 2'(k) - rd_offset[1:0];
      rd_byte = {1'b0, rd_offset} + 13'(rd_pos);
      s1_pos  = 2'(k) - s1_item.offset[1:0];
      s1_byte = {1'b0, s1_item.offset} + 13'(s1_pos);
      hit     = (32'(s1_byte) < RAM_BYTES) && ({1'b0, s1_pos} < nbytes);
    end

    // Clearing pass owns the write port until it ends
    always_comb begin
      if (clr.active) begin
        we    = 32'(clr.row) < ROWS;
        waddr = AW'(clr.row);
        wdata = 8'h00;
      end else begin
        we    = wr_en && hit;
        waddr = AW'(s1_byte >> 2);
        wdata = 8'(s1_item.wdata >> {s1_pos, 3'b000});
      end
    end

    sprb_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_lane (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (AW'(rd_byte >> 2)),
      .rdata (lane_q[k])
    );

    // Place the lane byte at its position in the read word
    assign lane_part[k] = hit ? (32'(lane_q[k]) << {s1_pos, 3'b000}) : 32'h0;
  end

  // Merge the lanes
  always_comb begin
    rdata = 32'h0;
    for (int k = 0; k < LANES; k++) begin
      rdata = rdata | lane_part[k];
    end
  end

endmodule

[sv/sprb_regs.sv]
// ----------------------------------------------------------------------------
// sprb_regs
// Control register file with set/clear/toggle aliases and the indirect
// sub-register store behind the indirect control register.
// ----------------------------------------------------------------------------
module sprb_regs #(
  parameter int REG_COUNT = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sprb_pkg::clr_t  clr,
  input  logic            rd_en,
  input  logic [11:0]     in_offset,
  input  logic [31:0]     in_wdata,
  input  sprb_pkg::item_t s1_item,
  input  logic            wr_en,
  output logic [31:0]     rdata,
  output logic [31:0]     ext_ctrl
);
  import sprb_pkg::*;

  localparam int AW = REG_COUNT > 1 ? $clog2(REG_COUNT) : 1;

  logic [31:0]       ext_ctrl_r, ext_ctrl_nxt;
  logic [31:0]       ai_ctrl_r, ai_ctrl_nxt;
  logic [31:0]       ai_wdata_r, ai_wdata_nxt;
  logic [31:0]       ai_rdata_r, ai_rdata_nxt;
  reg_sel_t          s1_sel;
  reg_sel_t          in_sel;
  logic              in_range;
  logic              special;
  logic [31:0]       ram_q;
  logic [31:0]       ind_q;
  logic [31:0]       cur;
  logic [31:0]       new_val;
  logic              wr_hit;
  logic              ai_trig;
  logic              reg_we;
  logic [AW-1:0]     reg_waddr;
  logic [31:0]       reg_wdata;
  logic              ind_we;
  logic [IND_AW-1:0] ind_waddr;
  logic [IND_AW-1:0] ind_raddr;

  // Decode the request in the input register
  always_comb begin
    s1_sel   = reg_select(s1_item.offset);
    in_range = 32'(s1_sel.idx) < REG_COUNT;
    special  = 1'b1;
    case (s1_sel.idx)
      IDX_EXT_CTRL: cur = ext_ctrl_r;
      IDX_AI_CTRL:  cur = ai_ctrl_r;
      IDX_AI_WDATA: cur = ai_wdata_r;
      IDX_AI_RDATA: cur = ai_rdata_r;
      default: begin
        cur     = ram_q;
        special = 1'b0;
      end
    endcase
    new_val = reg_apply(s1_sel.op, cur, s1_item.wdata);
    wr_hit  = wr_en && in_range;
    ai_trig = wr_hit && s1_sel.idx == IDX_AI_CTRL;
  end

  assign rdata    = in_range ? cur : 32'h0;
  assign ext_ctrl = ext_ctrl_r;

  // Next values of the registers held in flops
  always_comb begin
    ext_ctrl_nxt = ext_ctrl_r;
    ai_ctrl_nxt  = ai_ctrl_r;
    ai_wdata_nxt = ai_wdata_r;
    ai_rdata_nxt = ai_rdata_r;
    if (wr_hit && s1_sel.idx == IDX_EXT_CTRL) begin
      ext_ctrl_nxt = new_val;
    end
    if (wr_hit && s1_sel.idx == IDX_AI_WDATA) begin
      ai_wdata_nxt = new_val;
    end
    if (wr_hit && s1_sel.idx == IDX_AI_RDATA) begin
      ai_rdata_nxt = new_val;
    end
    if (ai_trig) begin
      // Mirror the toggle bits into the done bits
      ai_ctrl_nxt                  = new_val;
      ai_ctrl_nxt[AI_DONE_PLL_BIT] = new_val[AI_TOG_PLL_BIT];
      ai_ctrl_nxt[AI_DONE_PHY_BIT] = new_val[AI_TOG_PHY_BIT];
      if (new_val[AI_READ_BIT]) begin
        ai_rdata_nxt = ind_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_ctrl_r <= 32'h0;
      ai_ctrl_r  <= 32'h0;
      ai_wdata_r <= 32'h0;
      ai_rdata_r <= 32'h0;
    end else begin
      ext_ctrl_r <= ext_ctrl_nxt;
      ai_ctrl_r  <= ai_ctrl_nxt;
      ai_wdata_r <= ai_wdata_nxt;
      ai_rdata_r <= ai_rdata_nxt;
    end
  end

  // Register store write port: clearing pass or plain registers
  always_comb begin
    if (clr.active) begin
      reg_we    = 32'(clr.row) < REG_COUNT;
      reg_waddr = AW'(clr.row);
      reg_wdata = (clr.row == '0) ? VERSION_WORD : 32'h0;
    end else begin
      reg_we    = wr_hit && !special;
      reg_waddr = AW'(s1_sel.idx);
      reg_wdata = new_val;
    end
  end

  // Look ahead at the incoming request to fetch its words
  always_comb begin
    in_sel    = reg_select(in_offset);
    ind_raddr = IND_AW'(reg_apply(in_sel.op, ai_ctrl_nxt, in_wdata));
  end

  sprb_ram #(
    .WIDTH (32),
    .DEPTH (REG_COUNT)
  ) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .re    (rd_en),
    .raddr (AW'(in_sel.idx)),
    .rdata (ram_q)
  );

  // Indirect store write port: clearing pass or indirect write
  always_comb begin
    if (clr.active) begin
      ind_we    = 32'(clr.row) < IND_DEPTH;
      ind_waddr = IND_AW'(clr.row);
    end else begin
      ind_we    = ai_trig && !new_val[AI_READ_BIT];
      ind_waddr = new_val[IND_AW-1:0];
    end
  end

  sprb_ram #(
    .WIDTH (32),
    .DEPTH (IND_DEPTH)
  ) u_ind_ram (
    .clk   (clk),
    .we    (ind_we),
    .waddr (ind_waddr),
    .wdata (clr.active ? 32'h0 : ai_wdata_r),
    .re    (rd_en),
    .raddr (ind_raddr),
    .rdata (ind_q)
  );

endmodule

[sv/sprb_fifo.sv]
// ----------------------------------------------------------------------------
// sprb_fifo
// TX FIFO: pushes from bus writes, pops on active word ticks, and the DMA
// request against the watermark.
// ----------------------------------------------------------------------------
module sprb_fifo #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic                         push,
  input  logic [31:0]                  push_data,
  input  logic                         tick,
  input  logic [sprb_pkg::WM_W-1:0]    wm,
  output sprb_pkg::tx_res_t            res
);
  import sprb_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic          do_push;
  logic          do_pop;
  logic [31:0]   rd_q;

  // Drop a push to a full FIFO; pop only when not empty
  always_comb begin
    do_push    = push && 32'(fill_r) < FIFO_DEPTH;
    do_pop     = tick && fill_r != '0;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Prefetch the head word for the next request
  sprb_ram #(
    .WIDTH (32),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .re    (rd_en),
    .raddr (rd_ptr_nxt),
    .rdata (rd_q)
  );

  always_comb begin
    res.word  = do_pop ? rd_q : 32'h0;
    res.valid = do_pop;
    res.dreq  = tick && 32'(fill_nxt) <= 32'(wm);
    res.level = 6'(fill_nxt);
  end

endmodule

[sv/spdif_transceiver_register_block_unit.sv]
// ----------------------------------------------------------------------------
// spdif_transceiver_register_block_unit
// Bus-side register block of an S/PDIF transceiver: byte window RAM,
// aliased control registers, indirect sub-registers and the TX FIFO.
// ----------------------------------------------------------------------------
// One request (bus read, bus write or word-rate tick) is taken every cycle
// unless the output stalls: the request is registered while the addressed RAM
// words are fetched, then one pass of logic updates the state and loads the
// output register. The rate is set by the single read and write port of each
// memory, used once per request. After reset a clearing pass zeroes the window
// RAM, the register store (but for the version word in its first row) and the
// indirect store, one row per cycle, until the largest is cleared; in_stall
// stays high until it ends.
module spdif_transceiver_register_block_unit #(
  parameter int REG_COUNT  = 64,
  parameter int RAM_BYTES  = 2048,
  parameter int FIFO_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_wdata,
  input  logic [2:0]  in_access_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rdata,
  output logic        out_dma_request,
  output logic [31:0] out_tx_word,
  output logic        out_tx_word_valid,
  output logic [5:0]  out_tx_level
);
  import sprb_pkg::*;

  localparam int WIN_ROWS = (RAM_BYTES + 3) / 4;
  localparam int CLR_A    = WIN_ROWS > IND_DEPTH ? WIN_ROWS : IND_DEPTH;
  localparam int CLR_LEN  = CLR_A > REG_COUNT ? CLR_A : REG_COUNT;

  logic                 clr_active_r, clr_active_nxt;
  logic [CLR_ROW_W-1:0] clr_row_r, clr_row_nxt;
  clr_t                 clr;
  logic                 s1_valid_r, s1_valid_nxt;
  item_t                s1_item_r;
  logic                 accept;
  logic                 s1_adv;
  logic                 fire;
  logic                 is_ram;
  logic                 is_port;
  logic                 is_wr;
  logic                 tx_on;
  logic [31:0]          win_rdata;
  logic [31:0]          reg_rdata;
  logic [31:0]          ext_ctrl;
  tx_res_t              tx_res;
  logic [31:0]          rdata;
  logic                 out_valid_r;
  logic [31:0]          out_rdata_r;
  logic                 out_dreq_r;
  logic [31:0]          out_word_r;
  logic                 out_word_valid_r;
  logic [5:0]           out_level_r;

  // Clearing pass after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_row_nxt    = clr_row_r;
    if (clr_active_r) begin
      clr_row_nxt = clr_row_r + 1'b1;
      if (clr_row_r == CLR_ROW_W'(CLR_LEN - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_row_r    <= clr_row_nxt;
    end
  end

  assign clr.active = clr_active_r;
  assign clr.row    = clr_row_r;

  // Handshake: advance the input register when the output register frees up
  assign s1_adv   = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s1_adv;
  assign in_stall = clr_active_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.mode         <= mode_t'(in_mode);
      s1_item_r.offset       <= in_offset;
      s1_item_r.wdata        <= in_wdata;
      s1_item_r.access_bytes <= in_access_bytes;
    end
  end

  // Route the request
  always_comb begin
    is_ram  = 32'(s1_item_r.offset) < REG_BASE;
    is_port = s1_item_r.offset == OFF_RX_PORT || s1_item_r.offset == OFF_TX_PORT;
    is_wr   = fire && s1_item_r.mode == MODE_WRITE;
    tx_on   = ext_ctrl[EC_SPDIF_BIT] && !ext_ctrl[EC_DMA_WR_DIS_BIT] &&
              !ext_ctrl[EC_TX_RESET_BIT];
  end

  sprb_win #(
    .RAM_BYTES (RAM_BYTES)
  ) u_win (
    .clk       (clk),
    .clr       (clr),
    .rd_en     (accept),
    .rd_offset (in_offset),
    .s1_item   (s1_item_r),
    .wr_en     (is_wr && is_ram),
    .rdata     (win_rdata)
  );

  sprb_regs #(
    .REG_COUNT (REG_COUNT)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .rd_en     (accept),
    .in_offset (in_offset),
    .in_wdata  (in_wdata),
    .s1_item   (s1_item_r),
    .wr_en     (is_wr && !is_ram && !is_port),
    .rdata     (reg_rdata),
    .ext_ctrl  (ext_ctrl)
  );

  sprb_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .push      (is_wr && s1_item_r.offset == OFF_TX_PORT),
    .push_data (s1_item_r.wdata),
    .tick      (fire && s1_item_r.mode == MODE_TICK && tx_on),
    .wm        (ext_ctrl[WM_W-1:0]),
    .res       (tx_res)
  );

  // Select the read data
  always_comb begin
    rdata = 32'h0;
    if (s1_item_r.mode == MODE_READ) begin
      if (is_ram) begin
        rdata = win_rdata;
      end else if (!is_port) begin
        rdata = reg_rdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rdata_r      <= rdata;
      out_dreq_r       <= tx_res.dreq;
      out_word_r       <= tx_res.word;
      out_word_valid_r <= tx_res.valid;
      out_level_r      <= tx_res.level;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_rdata_r;
  assign out_dma_request   = out_dreq_r;
  assign out_tx_word       = out_word_r;
  assign out_tx_word_valid = out_word_valid_r;
  assign out_tx_level      = out_level_r;

endmodule

[sv/sprb_checker.sv]
// ----------------------------------------------------------------------------
// sprb_checker
// Port-level checks of the register block, bound to the top level.
// ----------------------------------------------------------------------------
module sprb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_mode,
  input logic [11:0] in_offset,
  input logic [31:0] in_wdata,
  input logic [2:0]  in_access_bytes,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_rdata,
  input logic        out_dma_request,
  input logic [31:0] out_tx_word,
  input logic        out_tx_word_valid,
  input logic [5:0]  out_tx_level
);

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rdata) &&
    $stable(out_tx_word) && $stable(out_tx_level))
    else $error("stalled response changed");

  // A word is shown only when popped
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_word_valid |-> out_tx_word == 32'h0)
    else $error("tx word without pop");

  // Read data and tick results never share a response
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rdata != 32'h0 |-> !out_tx_word_valid && !out_dma_request)
    else $error("read data mixed with tick result");

  // Requests are held off while memories clear after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall && !out_valid)
    else $error("request taken during clearing pass");

endmodule

bind spdif_transceiver_register_block_unit sprb_checker u_sprb_checker (.*);
